>>> hdl/sac_pkg.sv
package sac_pkg;

  localparam int CMD_W      = 2;
  localparam int IN_ADDR_W  = 64;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int SB_W       = 4;
  localparam int BB_W       = 5;
  localparam int WAYS_W     = 4;
  localparam int SB_EFF_W   = 5;
  localparam int SHIFT_W    = 6;

  localparam logic [CMD_W-1:0] CMD_MODIFY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INVALID = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [SB_W-1:0]   RST_SET_BITS   = 4'd4;
  localparam logic [BB_W-1:0]   RST_BLOCK_BITS = 5'd4;
  localparam logic [WAYS_W-1:0] RST_WAYS       = 4'd1;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  typedef struct packed {
    logic hit;
    logic evicted;
  } sac_res_t;

  typedef struct packed {
    logic fire;
    logic hit;
    logic evicted;
  } sac_event_t;

endpackage

>>> hdl/sac_ram.sv
module sac_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  // A read of the row written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/sac_split.sv
module sac_split #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64,
  parameter int NW_W         = 4
) (
  input  logic [ADDR_WIDTH-1:0]   address,
  input  logic [sac_pkg::SB_W-1:0]   set_bits,
  input  logic [sac_pkg::BB_W-1:0]   block_bits,
  input  logic [sac_pkg::WAYS_W-1:0] ways,
  output logic [MAX_SET_BITS-1:0] set_idx,
  output logic [ADDR_WIDTH-1:0]   tag,
  output logic [NW_W-1:0]         nw
);

  import sac_pkg::*;

  logic [SB_EFF_W-1:0]     sb_eff;
  logic [SHIFT_W-1:0]      tag_shift;
  logic [ADDR_WIDTH-1:0]   shifted;
  logic [MAX_SET_BITS-1:0] set_mask;

  always_comb begin
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb_eff = SB_EFF_W'(MAX_SET_BITS);
    end else begin
      sb_eff = SB_EFF_W'(set_bits);
    end
    tag_shift = SHIFT_W'(block_bits) + SHIFT_W'(sb_eff);
    shifted   = address >> block_bits;
    set_mask  = ~({MAX_SET_BITS{1'b1}} << sb_eff);
    set_idx   = shifted[MAX_SET_BITS-1:0] & set_mask;
    tag       = address >> tag_shift;
    if (ways == '0) begin
      nw = NW_W'(1);
    end else if (int'(ways) > MAX_WAYS) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = NW_W'(ways);
    end
  end

endmodule

>>> hdl/sac_lookup.sv
module sac_lookup #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64,
  parameter int WAY_W      = 3,
  parameter int NW_W       = 4,
  parameter int ROW_W      = 8
) (
  input  logic [ROW_W-1:0]      row,
  input  logic [ADDR_WIDTH-1:0] tag,
  input  logic [NW_W-1:0]       nw,
  output logic [ROW_W-1:0]      new_row,
  output sac_pkg::sac_res_t     res
);

  import sac_pkg::*;

  localparam int TAGS_W = MAX_WAYS * ADDR_WIDTH;

  logic [TAGS_W-1:0]   tags;
  logic [TAGS_W-1:0]   tags_n;
  logic [MAX_WAYS-1:0] valid;
  logic [MAX_WAYS-1:0] valid_n;
  logic [WAY_W-1:0]    recent;
  logic [WAY_W-1:0]    sel;
  logic                found;

  assign tags   = row[TAGS_W-1:0];
  assign valid  = row[TAGS_W +: MAX_WAYS];
  assign recent = row[ROW_W-1 -: WAY_W];

  // The first active way that holds the tag or is empty takes the access.
  // With none, the most recent way is replaced, or way 0 if it is out of range.
  always_comb begin
    found   = 1'b0;
    sel     = '0;
    res.hit = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!found && (int'(w) < int'(nw)) &&
          (!valid[w] || (tags[w*ADDR_WIDTH +: ADDR_WIDTH] == tag))) begin
        found   = 1'b1;
        sel     = WAY_W'(w);
        res.hit = valid[w];
      end
    end
    if (!found) begin
      if (int'(recent) >= int'(nw)) begin
        sel = '0;
      end else begin
        sel = recent;
      end
    end
    res.evicted = !found;
    tags_n = tags;
    tags_n[sel*ADDR_WIDTH +: ADDR_WIDTH] = tag;
    valid_n = valid;
    valid_n[sel] = 1'b1;
    new_row = {sel, valid_n, tags_n};
  end

endmodule

>>> hdl/sac_stats.sv
module sac_stats (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sac_pkg::sac_event_t          ev,
  output logic [sac_pkg::CNT_W-1:0]    hits_upd,
  output logic [sac_pkg::CNT_W-1:0]    misses_upd,
  output logic [sac_pkg::CNT_W-1:0]    evicts_upd
);

  import sac_pkg::*;

  logic [CNT_W-1:0] hits_r,   hits_nxt;
  logic [CNT_W-1:0] misses_r, misses_nxt;
  logic [CNT_W-1:0] evicts_r, evicts_nxt;

  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    evicts_nxt = evicts_r;
    if (ev.fire) begin
      if (ev.hit) begin
        if (hits_r != '1) begin
          hits_nxt = hits_r + 1'b1;
        end
      end else begin
        if (misses_r != '1) begin
          misses_nxt = misses_r + 1'b1;
        end
        if (ev.evicted && (evicts_r != '1)) begin
          evicts_nxt = evicts_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else begin
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
    end
  end

  assign hits_upd   = hits_nxt;
  assign misses_upd = misses_nxt;
  assign evicts_upd = evicts_nxt;

endmodule

>>> hdl/set_assoc_cache_tags_mru.sv
// The set row is read into the tag memory's output register and the lookup
// result into the output register; a modify reads its set again for its second
// result. A load or store is taken every cycle unless the output stalls;
// each access is one read and one write-back of its set row in the tag memory.
// Reset is synchronous and active low. After reset the tag memory is cleared
// one set per cycle, all 2**MAX_SET_BITS sets, with in_ready held low.
module set_assoc_cache_tags_mru #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sac_pkg::CMD_W-1:0]         in_command,
  input  logic [sac_pkg::IN_ADDR_W-1:0]     in_address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic                              out_evicted,
  output logic [sac_pkg::CNT_W-1:0]         out_hits_total,
  output logic [sac_pkg::CNT_W-1:0]         out_misses_total,
  output logic [sac_pkg::CNT_W-1:0]         out_evictions_total,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import sac_pkg::*;

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W   = $clog2(MAX_WAYS + 1);
  localparam int ROW_W  = WAY_W + MAX_WAYS + MAX_WAYS * ADDR_WIDTH;
  localparam int SET_W  = MAX_SET_BITS;

  state_t state_r, state_nxt;

  logic [SB_W-1:0]   set_bits_r;
  logic [BB_W-1:0]   block_bits_r;
  logic [WAYS_W-1:0] ways_r;

  logic [SET_W-1:0]      clr_idx_r;
  logic [SET_W-1:0]      set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic                  second_r;
  logic                  cmd_mod_r;

  logic [SET_W-1:0]      in_set;
  logic [ADDR_WIDTH-1:0] in_tag;
  logic [NW_W-1:0]       nw;

  logic                  rd_en;
  logic [SET_W-1:0]      rd_addr;
  logic [ROW_W-1:0]      rd_row;
  logic                  wr_en;
  logic [SET_W-1:0]      wr_addr;
  logic [ROW_W-1:0]      wr_row;
  logic [ROW_W-1:0]      new_row;

  sac_res_t   res;
  sac_event_t ev;

  logic             slot_free;
  logic             look_fin;
  logic             need_second;
  logic             in_fire;
  logic             start;
  logic [CNT_W-1:0] hits_upd, misses_upd, evicts_upd;

  logic             out_valid_r;
  logic             out_hit_r;
  logic             out_evicted_r;
  logic             out_last_r;
  logic [CNT_W-1:0] out_hits_r, out_misses_r, out_evicts_r;

  sac_split #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH),
    .NW_W         (NW_W)
  ) u_split (
    .address    (in_address[ADDR_WIDTH-1:0]),
    .set_bits   (set_bits_r),
    .block_bits (block_bits_r),
    .ways       (ways_r),
    .set_idx    (in_set),
    .tag        (in_tag),
    .nw         (nw)
  );

  sac_ram #(
    .ADDR_W (SET_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row)
  );

  sac_lookup #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .WAY_W      (WAY_W),
    .NW_W       (NW_W),
    .ROW_W      (ROW_W)
  ) u_lookup (
    .row     (rd_row),
    .tag     (tag_r),
    .nw      (nw),
    .new_row (new_row),
    .res     (res)
  );

  sac_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev         (ev),
    .hits_upd   (hits_upd),
    .misses_upd (misses_upd),
    .evicts_upd (evicts_upd)
  );

  assign slot_free   = !out_valid_r || out_ready;
  assign look_fin    = (state_r == S_LOOK) && slot_free;
  assign need_second = !second_r && look_fin && cmd_mod_r;
  assign in_ready    = (state_r == S_IDLE) || (look_fin && !need_second);
  assign in_fire     = in_valid && in_ready;
  assign start       = in_fire && (in_command != CMD_INVALID);

  assign ev = '{fire: look_fin, hit: res.hit, evicted: res.evicted};

  always_comb begin
    rd_en   = start || need_second;
    rd_addr = need_second ? set_r : in_set;
    wr_en   = (state_r == S_CLEAR) || look_fin;
    wr_addr = (state_r == S_CLEAR) ? clr_idx_r : set_r;
    wr_row  = (state_r == S_CLEAR) ? '0 : new_row;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (look_fin && !need_second && !start) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      set_bits_r   <= RST_SET_BITS;
      block_bits_r <= RST_BLOCK_BITS;
      ways_r       <= RST_WAYS;
      out_valid_r  <= 1'b0;
      second_r     <= 1'b0;
      cmd_mod_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits_r   <= cfg_data[SB_W-1:0];
          CFG_BLOCK_BITS: block_bits_r <= cfg_data[BB_W-1:0];
          CFG_WAYS:       ways_r       <= cfg_data[WAYS_W-1:0];
          default: ;
        endcase
      end
      if (look_fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (need_second) begin
        second_r <= 1'b1;
      end else if (start) begin
        second_r  <= 1'b0;
        cmd_mod_r <= (in_command == CMD_MODIFY);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      set_r <= in_set;
      tag_r <= in_tag;
    end
    if (look_fin) begin
      out_hit_r     <= res.hit;
      out_evicted_r <= res.evicted;
      out_last_r    <= !(cmd_mod_r && !second_r);
      out_hits_r    <= hits_upd;
      out_misses_r  <= misses_upd;
      out_evicts_r  <= evicts_upd;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_evicted         = out_evicted_r;
  assign out_last            = out_last_r;
  assign out_hits_total      = out_hits_r;
  assign out_misses_total    = out_misses_r;
  assign out_evictions_total = out_evicts_r;

endmodule
